>>> src/txs_pkg.sv
// ----------------------------------------------------------------------------
// txs_pkg
// Shared types, constants and arithmetic helpers for the texture sampler.
// ----------------------------------------------------------------------------
package txs_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int CFG_W          = 9;
   localparam int ADDR_W         = 16;
   localparam int TEXEL_W        = 24;
   localparam int COORD_W        = 17;
   localparam int FRAC_W         = 17;
   localparam int CHAN_OUT_W     = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam logic [FRAC_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [FRAC_W-1:0] HALF_Q16 = 17'h08000;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_PITCH  = 2'd2,
      REG_FILTER = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic {
      FILTER_NEAREST  = 1'b0,
      FILTER_BILINEAR = 1'b1
   } filter_type;

   typedef struct packed {
      logic [CFG_W-1:0] tex_width;
      logic [CFG_W-1:0] tex_height;
      logic [CFG_W-1:0] row_pitch;
      filter_type       filter_mode;
   } cfg_type;

   // one queued job: a texel write or a sample with its four fetch addresses
   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr00;
      logic [ADDR_W-1:0]   addr10;
      logic [ADDR_W-1:0]   addr01;
      logic [ADDR_W-1:0]   addr11;
      logic [FRAC_W-1:0]   frac_x;
      logic [FRAC_W-1:0]   frac_y;
      logic [TEXEL_W-1:0]  wdata;
   } job_type;

   // c0*(1-f) + c1*f in Q8.16, written as c0<<16 + (c1-c0)*f
   function automatic logic [23:0] lerp_h(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [FRAC_W-1:0] f);
      logic signed [8:0]  d;
      logic signed [26:0] s;
      d = $signed({1'b0, c1}) - $signed({1'b0, c0});
      s = $signed({3'b0, c0, 16'b0}) + 27'(d) * 27'($signed({1'b0, f}));
      return s[23:0];
   endfunction

   // top*(1-f) + bot*f in Q8.32, truncated to 8.8
   function automatic logic [CHAN_OUT_W-1:0] lerp_v(input logic [23:0] top,
                                                    input logic [23:0] bot,
                                                    input logic [FRAC_W-1:0] f);
      logic signed [24:0] d;
      logic signed [42:0] s;
      d = $signed({1'b0, bot}) - $signed({1'b0, top});
      s = $signed({3'b0, top, 16'b0}) + 43'(d) * 43'($signed({1'b0, f}));
      return s[39:24];
   endfunction

endpackage

>>> src/txs_front.sv
// ----------------------------------------------------------------------------
// txs_front
// Accepts items, scales coordinates, finds base texels and fractions and
// forms the store addresses of each job.
// ----------------------------------------------------------------------------
module txs_front import txs_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_operation,
   input  logic [ADDR_W-1:0]   in_texel_address,
   input  logic [TEXEL_W-1:0]  in_texel_value,
   input  logic [COORD_W-1:0]  in_coord_u,
   input  logic [COORD_W-1:0]  in_coord_v,
   output logic                push,
   input  logic                queue_full,
   output job_type             job
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SW      = $clog2(MAX_DIM + 1);
   localparam int IW      = $clog2(MAX_DIM);
   localparam int PW      = COORD_W + SW;

   logic                front_adv;
   logic [SW-1:0]       w_size, h_size;

   logic                f1_valid_ff, f1_valid_in;
   op_type              f1_op_ff;
   logic [ADDR_W-1:0]   f1_addr_ff;
   logic [TEXEL_W-1:0]  f1_value_ff;
   logic [COORD_W-1:0]  f1_u_ff, f1_v_ff;

   logic                f2_valid_ff;
   op_type              f2_op_ff;
   logic [ADDR_W-1:0]   f2_addr_ff;
   logic [TEXEL_W-1:0]  f2_value_ff;
   logic [PW-1:0]       f2_px_ff, f2_py_ff;

   logic                f3_valid_ff;
   op_type              f3_op_ff;
   logic [ADDR_W-1:0]   f3_addr_ff;
   logic [TEXEL_W-1:0]  f3_value_ff;
   logic [IW-1:0]       f3_x_ff, f3_y_ff, x_in, y_in;
   logic [FRAC_W-1:0]   f3_fx_ff, f3_fy_ff, fx_in, fy_in;

   logic [IW+CFG_W-1:0] row_off;
   logic [ADDR_W-1:0]   a00, a01;

   // clamp a size register into 2..max
   function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] s, input int maxv);
      logic [SW-1:0] r;
      if (s < CFG_W'(2))             r = SW'(2);
      else if (32'(s) > 32'(maxv))   r = SW'(maxv);
      else                           r = SW'(s);
      return r;
   endfunction

   // base index and fraction of one axis
   function automatic logic [IW+FRAC_W-1:0] axis(input logic [PW-1:0] p,
                                                 input logic [SW-1:0] size,
                                                 input filter_type mode);
      logic [PW-1:0]       q;
      logic [PW-1:0]       rem;
      logic [SW:0]         b;
      logic [SW:0]         bmax;
      logic [SW:0]         tmax;
      logic [IW-1:0]       base;
      logic [FRAC_W-1:0]   frac;
      q    = p - PW'(HALF_Q16);
      bmax = {1'b0, size} - (SW+1)'(2);
      tmax = {1'b0, size} - (SW+1)'(1);
      rem  = q - {bmax, 16'b0};
      base = '0;
      frac = '0;
      if (mode == FILTER_NEAREST) begin
         b    = p[PW-1:16];
         base = (b > tmax) ? IW'(tmax) : IW'(b);
      end else if (p >= PW'(HALF_Q16)) begin
         b = q[PW-1:16];
         if (b > bmax) begin
            base = IW'(bmax);
            frac = (rem > PW'(ONE_Q16)) ? ONE_Q16 : rem[FRAC_W-1:0];
         end else begin
            base = IW'(b);
            frac = {1'b0, q[15:0]};
         end
      end
      return {base, frac};
   endfunction

   assign w_size    = clamp_size(cfg.tex_width, MAX_WIDTH);
   assign h_size    = clamp_size(cfg.tex_height, MAX_HEIGHT);
   assign front_adv = !f3_valid_ff || !queue_full;
   assign in_ready  = front_adv;
   assign f1_valid_in = in_valid;

   // stage 1: capture
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f1_valid_ff <= f1_valid_in;
      end
      if (front_adv) begin
         f1_op_ff    <= op_type'(in_operation);
         f1_addr_ff  <= in_texel_address;
         f1_value_ff <= in_texel_value;
         f1_u_ff     <= in_coord_u;
         f1_v_ff     <= in_coord_v;
      end
   end

   // stage 2: scale coordinates by size
   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f2_valid_ff <= f1_valid_ff;
      end
      if (front_adv) begin
         f2_op_ff    <= f1_op_ff;
         f2_addr_ff  <= f1_addr_ff;
         f2_value_ff <= f1_value_ff;
         f2_px_ff    <= PW'(f1_u_ff) * PW'(w_size);
         f2_py_ff    <= PW'(f1_v_ff) * PW'(h_size);
      end
   end

   // stage 3: base and fraction per axis
   assign {x_in, fx_in} = axis(f2_px_ff, w_size, cfg.filter_mode);
   assign {y_in, fy_in} = axis(f2_py_ff, h_size, cfg.filter_mode);

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f3_valid_ff <= f2_valid_ff;
      end
      if (front_adv) begin
         f3_op_ff    <= f2_op_ff;
         f3_addr_ff  <= f2_addr_ff;
         f3_value_ff <= f2_value_ff;
         f3_x_ff     <= x_in;
         f3_y_ff     <= y_in;
         f3_fx_ff    <= fx_in;
         f3_fy_ff    <= fy_in;
      end
   end

   // store addresses, wrapping modulo the store depth
   assign row_off = f3_y_ff * cfg.row_pitch;
   assign a00     = ADDR_W'(row_off) + ADDR_W'(f3_x_ff);
   assign a01     = a00 + ADDR_W'(cfg.row_pitch);

   always_comb begin
      job.op     = f3_op_ff;
      job.frac_x = f3_fx_ff;
      job.frac_y = f3_fy_ff;
      job.wdata  = f3_value_ff;
      if (f3_op_ff == OP_WRITE) begin
         job.addr00 = f3_addr_ff;
         job.addr10 = f3_addr_ff;
         job.addr01 = f3_addr_ff;
         job.addr11 = f3_addr_ff;
      end else if (cfg.filter_mode == FILTER_NEAREST) begin
         job.addr00 = a00;
         job.addr10 = a00;
         job.addr01 = a00;
         job.addr11 = a00;
      end else begin
         job.addr00 = a00;
         job.addr10 = a00 + ADDR_W'(1);
         job.addr01 = a01;
         job.addr11 = a01 + ADDR_W'(1);
      end
   end

   assign push = f3_valid_ff && !queue_full;

endmodule

>>> src/txs_queue.sv
// ----------------------------------------------------------------------------
// txs_queue
// Short job queue that decouples the front and back halves.
// ----------------------------------------------------------------------------
module txs_queue import txs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff)) else $error("pointers disagree");

endmodule

>>> src/txs_back.sv
// ----------------------------------------------------------------------------
// txs_back
// Texel store, four-texel fetch and the bilinear blend of each sample.
// ----------------------------------------------------------------------------
module txs_back import txs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  job_type                job,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [CHAN_OUT_W-1:0]  out_red,
   output logic [CHAN_OUT_W-1:0]  out_green,
   output logic [CHAN_OUT_W-1:0]  out_blue
);

   localparam int DEPTH = 1 << ADDR_W;

   // two copies of the store, each with one write and two read ports
   logic [TEXEL_W-1:0]    mem_a [DEPTH];
   logic [TEXEL_W-1:0]    mem_b [DEPTH];

   logic                  back_adv;
   logic                  sample;

   logic                  b1_valid_ff;
   logic [TEXEL_W-1:0]    p00_ff, p10_ff, p01_ff, p11_ff;
   logic [FRAC_W-1:0]     b1_fx_ff, b1_fy_ff;

   logic                  b2_valid_ff;
   logic [23:0]           top_ff [3];
   logic [23:0]           bot_ff [3];
   logic [FRAC_W-1:0]     b2_fy_ff;

   logic                  b3_valid_ff;
   logic [CHAN_OUT_W-1:0] chan_ff [3];

   assign back_adv = !b3_valid_ff || out_ready;
   assign pop      = back_adv && !queue_empty;
   assign sample   = pop && (job.op == OP_SAMPLE);

   // store write and fetch
   always_ff @(posedge clock) begin
      if (pop && job.op == OP_WRITE) begin
         mem_a[job.addr00] <= job.wdata;
         mem_b[job.addr00] <= job.wdata;
      end
      if (sample) begin
         p00_ff <= mem_a[job.addr00];
         p10_ff <= mem_a[job.addr10];
         p01_ff <= mem_b[job.addr01];
         p11_ff <= mem_b[job.addr11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (back_adv) begin
         b1_valid_ff <= sample;
      end
      if (sample) begin
         b1_fx_ff <= job.frac_x;
         b1_fy_ff <= job.frac_y;
      end
   end

   // horizontal blends
   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (back_adv) begin
         b2_valid_ff <= b1_valid_ff;
      end
      if (back_adv) begin
         for (int k = 0; k < 3; k++) begin
            top_ff[k] <= lerp_h(p00_ff[8*k +: 8], p10_ff[8*k +: 8], b1_fx_ff);
            bot_ff[k] <= lerp_h(p01_ff[8*k +: 8], p11_ff[8*k +: 8], b1_fx_ff);
         end
         b2_fy_ff <= b1_fy_ff;
      end
   end

   // vertical blend into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else if (back_adv) begin
         b3_valid_ff <= b2_valid_ff;
      end
      if (back_adv) begin
         for (int k = 0; k < 3; k++) begin
            chan_ff[k] <= lerp_v(top_ff[k], bot_ff[k], b2_fy_ff);
         end
      end
   end

   assign out_valid = b3_valid_ff;
   assign out_red   = chan_ff[0];
   assign out_green = chan_ff[1];
   assign out_blue  = chan_ff[2];

endmodule

>>> src/texture_sampler_bilinear_nearest_unit.sv
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_nearest_unit
// RGB8 texture store with nearest and bilinear sampling at Q1.16 coords.
// ----------------------------------------------------------------------------
//  channel | ports                                        | beat
//  req     | req_valid/ready, operation, address, value, u, v | write or sample
//  rsp     | rsp_valid/ready, red, green, blue (8.8)      | one per sample
//  csr     | csr_valid/ready, index, data                 | register write
//
//  One item per cycle while rsp is not stalled; a sample's result passes three front
//  stages, the queue, the fetch register and two blend stages on its way to rsp.
//  Writes give no result. Reset clears control state and registers only; the
//  texel store holds nothing defined until written and needs no clearing pass.
//  rsp_ready low holds the back half; the job queue then fills and req_ready drops.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear_nearest_unit import txs_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [ADDR_W-1:0]      req_texel_address,
   input  logic [31:0]            req_texel_value,
   input  logic [COORD_W-1:0]     req_coord_u,
   input  logic [COORD_W-1:0]     req_coord_v,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAN_OUT_W-1:0]  rsp_red,
   output logic [CHAN_OUT_W-1:0]  rsp_green,
   output logic [CHAN_OUT_W-1:0]  rsp_blue,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    push, pop, queue_full, queue_empty;
   job_type push_job, pop_job;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_WIDTH:  cfg_in.tex_width   = csr_data;
            REG_HEIGHT: cfg_in.tex_height  = csr_data;
            REG_PITCH:  cfg_in.row_pitch   = csr_data;
            REG_FILTER: cfg_in.filter_mode = filter_type'(csr_data[0]);
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width   <= CFG_W'(256);
         cfg_ff.tex_height  <= CFG_W'(256);
         cfg_ff.row_pitch   <= CFG_W'(256);
         cfg_ff.filter_mode <= FILTER_BILINEAR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   txs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_operation     (req_operation),
      .in_texel_address (req_texel_address),
      .in_texel_value   (req_texel_value[TEXEL_W-1:0]),
      .in_coord_u       (req_coord_u),
      .in_coord_v       (req_coord_v),
      .push             (push),
      .queue_full       (queue_full),
      .job              (push_job)
   );

   txs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_job  (pop_job)
   );

   txs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job         (pop_job),
      .pop         (pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_red     (rsp_red),
      .out_green   (rsp_green),
      .out_blue    (rsp_blue)
   );

endmodule

>>> verif/texture_sampler_bilinear_nearest_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_nearest_unit_tb
// Writes texels into the store and samples them in nearest and bilinear mode across
// several texture sizes and row pitches. Each sample's 8.8 color is predicted
// in the bench and checked against the rsp beats in order. Both sides idle at
// random outside the final phase; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear_nearest_unit_tb;
   import txs_pkg::*;

   typedef struct {
      op_type      op;
      logic [15:0] addr;
      logic [31:0] value;
      logic [16:0] u;
      logic [16:0] v;
   } texel_job_type;

   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } color_type;

   localparam longint ONE = 65536;
   localparam int     CYCLE_LIMIT = 2000000;
   localparam int     PHASE_ITEMS = 219;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_operation = 0;
   logic [15:0] req_texel_address = 0;
   logic [31:0] req_texel_value = 0;
   logic [16:0] req_coord_u = 0;
   logic [16:0] req_coord_v = 0;
   logic        rsp_valid;
   logic        rsp_ready = 1;
   logic [15:0] rsp_red, rsp_green, rsp_blue;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_WIDTH;
   logic [8:0]  csr_data = 0;

   texture_sampler_bilinear_nearest_unit dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // shadow of the block's registers and store
   logic [8:0]  sh_width = 256, sh_height = 256, sh_pitch = 256;
   filter_type  sh_filter = FILTER_BILINEAR;
   logic [23:0] texels [65536];
   bit          loaded [65536];

   texel_job_type pending_jobs [$];
   color_type     colors_due [$];
   int  errors = 0;
   int  cycles = 0;
   int  queued = 0;
   bit  calm = 0;
   bit  req_took = 0;
   int  req_gap = 0, rsp_gap = 0, long_hold = 0;
   bit  long_hold_req = 0, long_hold_done = 0;

   function automatic longint eff_size(logic [8:0] s);
      if (s < 2) return 2;
      if (s > 256) return 256;
      return s;
   endfunction

   function automatic logic [15:0] store_addr(longint row, longint col);
      return 16'((row * sh_pitch + col) & 'hFFFF);
   endfunction

   function automatic longint near_index(logic [16:0] c, longint size);
      longint t;
      t = (longint'(c) * size) >>> 16;
      return (t > size - 1) ? size - 1 : t;
   endfunction

   function automatic void blend_axis(logic [16:0] c, longint size,
                                      output longint base, output longint frac);
      longint pos;
      pos = longint'(c) * size - ONE / 2;
      base = ((pos + ONE) >>> 16) - 1;
      if (base < 0) base = 0;
      if (base > size - 2) base = size - 2;
      frac = pos - base * ONE;
      if (frac < 0) frac = 0;
      if (frac > ONE) frac = ONE;
   endfunction

   // store entries a sample touches: 1 in nearest mode, 4 in bilinear
   function automatic void fetch_addrs(logic [16:0] u, logic [16:0] v,
                                       output logic [15:0] a [4], output int n,
                                       output longint fx, output longint fy);
      longint x, y;
      if (sh_filter == FILTER_NEAREST) begin
         a[0] = store_addr(near_index(v, eff_size(sh_height)),
                           near_index(u, eff_size(sh_width)));
         n = 1; fx = 0; fy = 0;
      end else begin
         blend_axis(u, eff_size(sh_width), x, fx);
         blend_axis(v, eff_size(sh_height), y, fy);
         a[0] = store_addr(y, x);
         a[1] = store_addr(y, x + 1);
         a[2] = store_addr(y + 1, x);
         a[3] = store_addr(y + 1, x + 1);
         n = 4;
      end
   endfunction

   function automatic color_type sample_color(logic [16:0] u, logic [16:0] v);
      logic [15:0] a [4];
      int n;
      longint fx, fy, top, bot, acc;
      logic [15:0] ch [3];
      fetch_addrs(u, v, a, n, fx, fy);
      for (int k = 0; k < 3; k++) begin
         if (n == 1) ch[k] = {texels[a[0]][8*k +: 8], 8'h00};
         else begin
            top = longint'(texels[a[0]][8*k +: 8]) * (ONE - fx)
                + longint'(texels[a[1]][8*k +: 8]) * fx;
            bot = longint'(texels[a[2]][8*k +: 8]) * (ONE - fx)
                + longint'(texels[a[3]][8*k +: 8]) * fx;
            acc = top * (ONE - fy) + bot * fy;
            ch[k] = 16'((acc >>> 24) & 'hFFFF);
         end
      end
      return {ch[0], ch[1], ch[2]};
   endfunction

   function automatic void queue_write(logic [15:0] addr, logic [31:0] value);
      texel_job_type j;
      j.op = OP_WRITE; j.addr = addr; j.value = value;
      j.u = 17'($urandom); j.v = 17'($urandom);
      loaded[addr] = 1;
      pending_jobs.push_back(j);
      queued++;
   endfunction

   // a sample, preceded by writes for any texel it reads that was never loaded
   function automatic void queue_sample(logic [16:0] u, logic [16:0] v);
      texel_job_type j;
      logic [15:0] a [4];
      int n;
      longint fx, fy;
      fetch_addrs(u, v, a, n, fx, fy);
      for (int i = 0; i < n; i++)
         if (!loaded[a[i]]) queue_write(a[i], $urandom);
      j.op = OP_SAMPLE; j.u = u; j.v = v;
      j.addr = 16'($urandom); j.value = $urandom;
      pending_jobs.push_back(j);
      queued++;
   endfunction

   function automatic logic [16:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65000, 65536));
         3: return 17'($urandom_range(0, 600));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic csr_write(csr_index_type idx, logic [8:0] data);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_config(logic [8:0] w, logic [8:0] h, logic [8:0] p, filter_type f);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_PITCH, p);
      csr_write(REG_FILTER, 9'(f));
      sh_width = w; sh_height = h; sh_pitch = p; sh_filter = f;
   endtask

   task automatic drain();
      wait (pending_jobs.size() == 0 && !req_valid && colors_due.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // sender: next beat at the falling edge, random gaps between beats
   always @(negedge clock) begin
      if (reset) req_valid <= 0;
      else if (req_valid && !req_took) begin
      end else if (!calm && req_gap > 0) begin
         req_gap--;
         req_valid <= 0;
      end else if (pending_jobs.size() > 0) begin
         texel_job_type j;
         j = pending_jobs.pop_front();
         req_valid <= 1;
         req_operation <= j.op;
         req_texel_address <= j.addr;
         req_texel_value <= j.value;
         req_coord_u <= j.u;
         req_coord_v <= j.v;
         if ($urandom_range(0, 11) == 0) req_gap = $urandom_range(1, 16);
      end else req_valid <= 0;
      req_took = 0;
   end

   // receiver stalls, with one long hold-off that lets the queue fill
   always @(negedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         long_hold = 400;
         long_hold_done = 1;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_ready <= 0;
      end else if (calm) rsp_ready <= 1;
      else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if ($urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 16);
      end
   end

   // accepted req beats update the shadow store and predict colors; rsp beats are checked
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout", $realtime);
         $display("texture_sampler_bilinear_nearest_unit_tb: done, errors");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         req_took = 1;
         if (req_operation == OP_WRITE) texels[req_texel_address] = req_texel_value[23:0];
         else colors_due.push_back(sample_color(req_coord_u, req_coord_v));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (colors_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat r=%h g=%h b=%h", $realtime,
                     rsp_red, rsp_green, rsp_blue);
         end else begin
            color_type c;
            c = colors_due.pop_front();
            if (rsp_red !== c.r) begin
               errors++;
               $display("%0t: red expected %h actual %h", $realtime, c.r, rsp_red);
            end
            if (rsp_green !== c.g) begin
               errors++;
               $display("%0t: green expected %h actual %h", $realtime, c.g, rsp_green);
            end
            if (rsp_blue !== c.b) begin
               errors++;
               $display("%0t: blue expected %h actual %h", $realtime, c.b, rsp_blue);
            end
         end
      end
   end

   initial begin
      logic [8:0]  pw [7];
      logic [8:0]  ph [7];
      logic [8:0]  pp [7];
      filter_type  pf [7];
      logic [16:0] corner [6];
      pw = '{256, 256, 2,   2,   0,   511, 37};
      ph = '{256, 256, 2,   2,   1,   300, 19};
      pp = '{256, 300, 2,   511, 5,   0,   40};
      pf = '{FILTER_BILINEAR, FILTER_NEAREST, FILTER_BILINEAR, FILTER_NEAREST,
             FILTER_BILINEAR, FILTER_BILINEAR, FILTER_NEAREST};
      corner = '{0, 65536, 1, 65535, 32768, 128};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int ph_i = 0; ph_i < 8; ph_i++) begin
         drain();
         if (ph_i < 7) set_config(pw[ph_i], ph[ph_i], pp[ph_i], pf[ph_i]);
         else begin
            set_config(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)),
                       9'($urandom_range(0, 511)), filter_type'($urandom_range(0, 1)));
            calm = 1;
         end
         if (ph_i == 1) long_hold_req = 1;
         // corners, center and extreme write fields
         if (ph_i < 2) begin
            queue_write(16'h0000, 32'h0000_0000);
            queue_write(16'hFFFF, 32'hFFFF_FFFF);
            queue_write(16'h0001, 32'hFFFF_FFFF);
            for (int i = 0; i < 6; i++) queue_sample(corner[i], corner[5 - i]);
            queue_sample(17'd65536, 17'd65536);
            queue_sample(17'd0, 17'd0);
         end
         // fill the phase up to its share of beats, fill writes included
         while (queued < PHASE_ITEMS * (ph_i + 1)) begin
            if ($urandom_range(0, 5) == 0) queue_write(16'($urandom), $urandom);
            else queue_sample(pick_coord(), pick_coord());
         end
      end
      drain();

      if (errors == 0) $display("texture_sampler_bilinear_nearest_unit_tb: done, clean");
      else $display("texture_sampler_bilinear_nearest_unit_tb: done, errors");
      $finish;
   end

endmodule
